// File: hdl/lbc_pkg.sv
// Shared types and constants for the LED blink controller.
package lbc_pkg;

    typedef enum logic [2:0] {
        OP_OPEN   = 3'd0,
        OP_CLOSE  = 3'd1,
        OP_TOGGLE = 3'd2,
        OP_BLINK  = 3'd3,
        OP_TICK   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_VISIT,
        ST_MUL_PROD,
        ST_MUL_DIV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // mode bits per LED
    localparam logic [2:0] MODE_ON    = 3'h1;
    localparam logic [2:0] MODE_BLINK = 3'h2;
    localparam logic [2:0] MODE_FLASH = 3'h4;

    localparam logic [6:0] FULL_PCT = 7'd100;

    // shared multiplier operand widths
    localparam int MUL_A_W = 23;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // x / 100 == (x * ceil(2^30 / 100)) >> 30, exact for x < 2^23
    localparam logic [MUL_B_W-1:0] RECIP_100   = 24'd10737419;
    localparam int                 RECIP_SHIFT = 30;

    localparam int CFG_ADDR_W = 2;

    // register byte addresses
    localparam logic [CFG_ADDR_W-1:0] ADDR_ON_LEVEL_MASK = 2'd0;

endpackage

// File: hdl/lbc_mul.sv
// Shared multiplier with registered product.
module lbc_mul (
    input  logic                          clk,
    input  logic [lbc_pkg::MUL_A_W-1:0]   mul_a,
    input  logic [lbc_pkg::MUL_B_W-1:0]   mul_b,
    output logic [lbc_pkg::MUL_P_W-1:0]   prod
);

    logic [lbc_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= lbc_pkg::MUL_P_W'(mul_a) * lbc_pkg::MUL_P_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule

// File: hdl/lbc_apb_regs.sv
// APB configuration register: per-LED lit polarity.
module lbc_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lbc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [2:0]                      on_level_mask
);

    logic [2:0] mask_reg;
    logic [2:0] mask_next;
    logic       wr_en;
    logic       sel_mask;

    assign sel_mask = (paddr == lbc_pkg::ADDR_ON_LEVEL_MASK);
    assign wr_en    = psel && penable && pwrite && sel_mask;

    always_comb
    begin
        mask_next = mask_reg;
        if (wr_en)
        begin
            mask_next = pwdata[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 3'd6;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    assign prdata        = sel_mask ? {29'd0, mask_reg} : 32'd0;
    assign pready        = 1'b1;
    assign on_level_mask = mask_reg;

endmodule

// File: hdl/led_blink_controller.sv
// LED blink controller top level: command sequencer and per-LED state.
//
// Commands enter on start/busy: a beat is taken when start is high and busy
// is low. op selects open, close, toggle, blink or a one millisecond tick;
// led_index, blink_count, on_percent and blink_period go with it.
// One result beat follows every command: done is high for one cycle with
// pin_levels (driven level per LED, polarity from on_level_mask) and
// next_wait (smallest nonzero ms until a blinking LED changes, 0 if none).
// The receiver cannot stall; it must take the beat in that cycle.
// Steps: ST_CMD, then ST_VISIT for each LED; an LED that switches phase on a
// tick and keeps blinking adds ST_MUL_PROD, ST_MUL_DIV and ST_UPDATE (the
// duty wait uses the shared multiplier twice: once for percent * period, once
// for the reciprocal divide by 100); then ST_DONE and the result cycle. busy
// drops as the result beat goes out, so the next command can be taken in the
// result cycle; one command is in flight at a time. The user writes
// on_level_mask over the APB port only while idle; the block does not enforce
// this. Reset value 6. Reset (rst_n low, asynchronous) clears all LEDs to
// unlit, closed, not blinking, and the millisecond clock to zero.
module led_blink_controller #(
    parameter int NUM_LEDS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      op,
    input  logic [1:0]                      led_index,
    input  logic [7:0]                      blink_count,
    input  logic [6:0]                      on_percent,
    input  logic [15:0]                     blink_period,
    output logic                            done,
    output logic [2:0]                      pin_levels,
    output logic [15:0]                     next_wait,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lbc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int IDX_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int PIN_LEDS = (NUM_LEDS < 3) ? NUM_LEDS : 3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

    lbc_pkg::state_t state_reg, state_next;

    // latched command
    logic [2:0]  op_reg;
    logic        in_range_reg;
    logic [7:0]  count_reg;
    logic [6:0]  pct_in_reg;
    logic [15:0] period_in_reg;

    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [31:0]      now_reg, now_next;
    logic [15:0]      best_reg, best_next;
    logic [6:0]       pct_reg, pct_next;
    logic             done_reg, done_next;
    logic [2:0]       pins_reg, pins_next;
    logic [15:0]      wait_reg, wait_next;

    // per-LED state, addressed through ptr_reg; lit_reg is also read per LED
    logic [2:0]          mode_reg    [NUM_LEDS];
    logic [7:0]          blinks_reg  [NUM_LEDS];
    logic [6:0]          duty_reg    [NUM_LEDS];
    logic [15:0]         period_reg  [NUM_LEDS];
    logic [31:0]         change_reg  [NUM_LEDS];
    logic [NUM_LEDS-1:0] restore_reg;
    logic [NUM_LEDS-1:0] lit_reg;

    logic        e_we;
    logic [2:0]  e_mode_next;
    logic [7:0]  e_blinks_next;
    logic [6:0]  e_duty_next;
    logic [15:0] e_period_next;
    logic [31:0] e_change_next;
    logic        e_restore_next;
    logic        e_lit_next;

    logic [2:0]  cur_mode;
    logic [7:0]  cur_blinks;
    logic [6:0]  cur_duty;
    logic [15:0] cur_period;
    logic [31:0] cur_change;

    logic        accept;
    logic        is_tick;
    logic        due;
    logic [15:0] diff;
    logic        needs_mul;
    logic        last_led;
    logic [2:0]  on_level_mask;

    logic [lbc_pkg::MUL_A_W-1:0] mul_a;
    logic [lbc_pkg::MUL_B_W-1:0] mul_b;
    logic [lbc_pkg::MUL_P_W-1:0] prod;
    logic [15:0]                 phase_w;

    lbc_apb_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .on_level_mask (on_level_mask)
    );

    lbc_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign busy   = (state_reg != lbc_pkg::ST_IDLE);
    assign accept = start && !busy;

    assign cur_mode   = mode_reg[ptr_reg];
    assign cur_blinks = blinks_reg[ptr_reg];
    assign cur_duty   = duty_reg[ptr_reg];
    assign cur_period = period_reg[ptr_reg];
    assign cur_change = change_reg[ptr_reg];

    assign is_tick  = (op_reg == lbc_pkg::OP_TICK);
    assign due      = !(now_reg < cur_change);
    assign diff     = 16'(cur_change - now_reg);
    assign last_led = (ptr_reg == LAST_IDX);
    assign phase_w  = prod[lbc_pkg::RECIP_SHIFT +: 16];

    // a due LED that keeps blinking needs a phase wait from the multiplier
    assign needs_mul = is_tick && cur_mode[1] && due &&
                       (cur_mode[0] || cur_blinks != 8'd0 || cur_mode[2]);

    function automatic logic [15:0] fold_min(input logic [15:0] best,
                                             input logic [15:0] w);
        logic [15:0] r;
        r = best;
        if (best == 16'd0 || (w != 16'd0 && w < best))
        begin
            r = w;
        end
        return r;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lbc_pkg::ST_CMD;
                end
            end
            lbc_pkg::ST_CMD:
            begin
                state_next = lbc_pkg::ST_VISIT;
            end
            lbc_pkg::ST_VISIT:
            begin
                if (needs_mul)
                begin
                    state_next = lbc_pkg::ST_MUL_PROD;
                end
                else if (last_led)
                begin
                    state_next = lbc_pkg::ST_DONE;
                end
            end
            lbc_pkg::ST_MUL_PROD:
            begin
                state_next = lbc_pkg::ST_MUL_DIV;
            end
            lbc_pkg::ST_MUL_DIV:
            begin
                state_next = lbc_pkg::ST_UPDATE;
            end
            lbc_pkg::ST_UPDATE:
            begin
                state_next = last_led ? lbc_pkg::ST_DONE : lbc_pkg::ST_VISIT;
            end
            lbc_pkg::ST_DONE:
            begin
                state_next = lbc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lbc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb
    begin
        logic [2:0] eff_op;

        eff_op         = op_reg;
        e_we           = 1'b0;
        e_mode_next    = cur_mode;
        e_blinks_next  = cur_blinks;
        e_duty_next    = cur_duty;
        e_period_next  = cur_period;
        e_change_next  = cur_change;
        e_restore_next = restore_reg[ptr_reg];
        e_lit_next     = lit_reg[ptr_reg];
        ptr_next       = ptr_reg;
        now_next       = now_reg;
        best_next      = best_reg;
        pct_next       = pct_reg;
        done_next      = 1'b0;
        pins_next      = pins_reg;
        wait_next      = wait_reg;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            lbc_pkg::ST_IDLE:
            begin
                // an out-of-range index parks the pointer on LED 0; nothing is written
                if (accept && (32'(led_index) < NUM_LEDS))
                begin
                    ptr_next = IDX_W'(led_index);
                end
                else if (accept)
                begin
                    ptr_next = '0;
                end
            end
            lbc_pkg::ST_CMD:
            begin
                ptr_next  = '0;
                best_next = 16'd0;
                if (is_tick)
                begin
                    now_next = now_reg + 32'd1;
                end
                else if (in_range_reg && op_reg <= lbc_pkg::OP_BLINK)
                begin
                    if (op_reg == lbc_pkg::OP_TOGGLE)
                    begin
                        eff_op = cur_mode[0] ? lbc_pkg::OP_CLOSE : lbc_pkg::OP_OPEN;
                    end
                    if (eff_op == lbc_pkg::OP_OPEN)
                    begin
                        e_we        = 1'b1;
                        e_mode_next = lbc_pkg::MODE_ON;
                        e_lit_next  = 1'b1;
                    end
                    else if (eff_op == lbc_pkg::OP_CLOSE)
                    begin
                        e_we        = 1'b1;
                        e_mode_next = 3'd0;
                        e_lit_next  = 1'b0;
                    end
                    else if (pct_in_reg != 7'd0 && period_in_reg != 16'd0)
                    begin
                        e_we = 1'b1;
                        if (!cur_mode[1])
                        begin
                            e_restore_next = cur_mode[0];
                        end
                        e_mode_next   = lbc_pkg::MODE_BLINK |
                                        ((count_reg == 8'd0) ? lbc_pkg::MODE_FLASH : 3'd0);
                        e_period_next = period_in_reg;
                        e_duty_next   = (pct_in_reg > lbc_pkg::FULL_PCT) ?
                                        lbc_pkg::FULL_PCT : pct_in_reg;
                        e_blinks_next = count_reg;
                        e_change_next = now_reg;
                    end
                end
            end
            lbc_pkg::ST_VISIT:
            begin
                if (cur_mode[1])
                begin
                    if (!is_tick)
                    begin
                        best_next = fold_min(best_reg, due ? 16'd0 : diff);
                    end
                    else if (!due)
                    begin
                        best_next = fold_min(best_reg, diff);
                    end
                    else if (cur_mode[0])
                    begin
                        // on phase ends: go dark
                        e_we        = 1'b1;
                        pct_next    = lbc_pkg::FULL_PCT - cur_duty;
                        e_mode_next = cur_mode & ~lbc_pkg::MODE_ON;
                        e_lit_next  = 1'b0;
                        if (!cur_mode[2])
                        begin
                            e_blinks_next = cur_blinks - 8'd1;
                        end
                    end
                    else if (cur_blinks == 8'd0 && !cur_mode[2])
                    begin
                        // blink run over: back to the state before it
                        e_we           = 1'b1;
                        e_mode_next    = restore_reg[ptr_reg] ? lbc_pkg::MODE_ON : 3'd0;
                        e_lit_next     = restore_reg[ptr_reg];
                        e_restore_next = 1'b0;
                    end
                    else
                    begin
                        e_we        = 1'b1;
                        pct_next    = cur_duty;
                        e_mode_next = cur_mode | lbc_pkg::MODE_ON;
                        e_lit_next  = 1'b1;
                    end
                end
                if (!needs_mul && !last_led)
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            lbc_pkg::ST_MUL_PROD:
            begin
                mul_a = lbc_pkg::MUL_A_W'(pct_reg);
                mul_b = lbc_pkg::MUL_B_W'(cur_period);
            end
            lbc_pkg::ST_MUL_DIV:
            begin
                mul_a = prod[lbc_pkg::MUL_A_W-1:0];
                mul_b = lbc_pkg::RECIP_100;
            end
            lbc_pkg::ST_UPDATE:
            begin
                e_we          = 1'b1;
                e_change_next = now_reg + 32'(phase_w);
                best_next     = fold_min(best_reg, phase_w);
                if (!last_led)
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            lbc_pkg::ST_DONE:
            begin
                done_next = 1'b1;
                wait_next = best_reg;
                pins_next = 3'd0;
                for (int i = 0; i < PIN_LEDS; i++)
                begin
                    pins_next[i] = lit_reg[i] ? on_level_mask[i] : ~on_level_mask[i];
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op;
            in_range_reg  <= (32'(led_index) < NUM_LEDS);
            count_reg     <= blink_count;
            pct_in_reg    <= on_percent;
            period_in_reg <= blink_period;
        end
        pct_reg  <= pct_next;
        pins_reg <= pins_next;
        wait_reg <= wait_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lbc_pkg::ST_IDLE;
            ptr_reg     <= '0;
            now_reg     <= 32'd0;
            best_reg    <= 16'd0;
            done_reg    <= 1'b0;
            restore_reg <= '0;
            lit_reg     <= '0;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                mode_reg[i]   <= 3'd0;
                blinks_reg[i] <= 8'd0;
                duty_reg[i]   <= 7'd0;
                period_reg[i] <= 16'd0;
                change_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            now_reg   <= now_next;
            best_reg  <= best_next;
            done_reg  <= done_next;
            if (e_we)
            begin
                mode_reg[ptr_reg]    <= e_mode_next;
                blinks_reg[ptr_reg]  <= e_blinks_next;
                duty_reg[ptr_reg]    <= e_duty_next;
                period_reg[ptr_reg]  <= e_period_next;
                change_reg[ptr_reg]  <= e_change_next;
                restore_reg[ptr_reg] <= e_restore_next;
                lit_reg[ptr_reg]     <= e_lit_next;
            end
        end
    end

    assign done       = done_reg;
    assign pin_levels = pins_reg;
    assign next_wait  = wait_reg;

    // one result beat per command, never two in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= LAST_IDX)
        else $error("LED pointer out of range");

    a_now_only_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(now_reg) |-> $past(state_reg) == lbc_pkg::ST_CMD)
        else $error("millisecond clock moved outside command step");

    a_flash_needs_blink: assert property (@(posedge clk) disable iff (!rst_n)
        !(cur_mode[2] && !cur_mode[1]))
        else $error("flash mode set without blink mode");

endmodule

// File: test/tb_led_blink_controller.sv
// Self-checking testbench for led_blink_controller: command driver, result monitor, predictor.
module tb_led_blink_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEDS = 3;

    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_MASK,
        JOB_DRAIN
    } job_kind_t;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_CMD,
        DRV_SETUP,
        DRV_ACCESS,
        DRV_RSETUP,
        DRV_RACCESS
    } drv_state_t;

    typedef struct {
        job_kind_t   kind;
        logic [2:0]  op;
        logic [1:0]  led_index;
        logic [7:0]  blink_count;
        logic [6:0]  on_percent;
        logic [15:0] blink_period;
        logic [2:0]  mask_value;
        int          gap_pct;
    } job_t;

    typedef struct {
        logic [2:0]  pins;
        logic [15:0] wait_ms;
    } status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  op = '0;
    logic [1:0]  led_index = '0;
    logic [7:0]  blink_count = '0;
    logic [6:0]  on_percent = '0;
    logic [15:0] blink_period = '0;
    logic        done;
    logic [2:0]  pin_levels;
    logic [15:0] next_wait;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [lbc_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    led_blink_controller #(.NUM_LEDS(NUM_LEDS)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .led_index    (led_index),
        .blink_count  (blink_count),
        .on_percent   (on_percent),
        .blink_period (blink_period),
        .done         (done),
        .pin_levels   (pin_levels),
        .next_wait    (next_wait),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // predictor state
    logic [2:0]  level_mask;
    logic [2:0]  led_mode [NUM_LEDS];
    logic [7:0]  blinks_to_go [NUM_LEDS];
    logic [6:0]  duty_pct [NUM_LEDS];
    logic [15:0] period_ms [NUM_LEDS];
    logic [31:0] due_ms [NUM_LEDS];
    logic        lit_after_blink [NUM_LEDS];
    logic        led_on [NUM_LEDS];
    logic [31:0] clock_ms;

    job_t       command_q [$];
    status_t    expected_status_q [$];
    drv_state_t drv_state = DRV_IDLE;
    int         sender_gap_pct;
    int         mismatches = 0;
    int         results_seen = 0;
    int         cmds_accepted = 0;
    int         ticks_seen = 0;
    int         blinks_started = 0;
    int         runs_finished = 0;
    int         masks_written = 0;

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic logic [15:0] min_wait(logic [15:0] best, logic [15:0] w);
        if (best == 16'd0 || (w != 16'd0 && w < best))
            return w;
        return best;
    endfunction

    // one tick for a blinking LED: switch phase if due, return wait to next change
    function automatic logic [15:0] advance_led(int i);
        logic [15:0] w;
        logic [6:0]  pct;
        if (clock_ms < due_ms[i])
            return 16'(due_ms[i] - clock_ms);
        if ((led_mode[i] & lbc_pkg::MODE_ON) != 3'h0)
        begin
            pct = lbc_pkg::FULL_PCT - duty_pct[i];
            led_mode[i] = led_mode[i] & ~lbc_pkg::MODE_ON;
            led_on[i] = 1'b0;
            if ((led_mode[i] & lbc_pkg::MODE_FLASH) == 3'h0)
                blinks_to_go[i] = blinks_to_go[i] - 8'd1;
        end
        else if (blinks_to_go[i] == 8'd0 && (led_mode[i] & lbc_pkg::MODE_FLASH) == 3'h0)
        begin
            led_mode[i] = lit_after_blink[i] ? lbc_pkg::MODE_ON : 3'h0;
            led_on[i] = lit_after_blink[i];
            lit_after_blink[i] = 1'b0;
            runs_finished++;
            return 16'd0;
        end
        else
        begin
            pct = duty_pct[i];
            led_mode[i] = led_mode[i] | lbc_pkg::MODE_ON;
            led_on[i] = 1'b1;
        end
        w = 16'((32'(pct) * 32'(period_ms[i])) / 32'd100);
        due_ms[i] = clock_ms + 32'(w);
        return w;
    endfunction

    function automatic status_t predict_status(job_t c);
        status_t     s;
        logic [2:0]  eff;
        logic [15:0] best;
        int          idx;
        eff = c.op;
        idx = int'(c.led_index);
        best = 16'd0;
        if (c.op <= lbc_pkg::OP_BLINK && idx < NUM_LEDS)
        begin
            if (eff == lbc_pkg::OP_TOGGLE)
                eff = ((led_mode[idx] & lbc_pkg::MODE_ON) != 3'h0) ?
                      lbc_pkg::OP_CLOSE : lbc_pkg::OP_OPEN;
            case (eff)
                lbc_pkg::OP_OPEN:
                begin
                    led_mode[idx] = lbc_pkg::MODE_ON;
                    led_on[idx] = 1'b1;
                end
                lbc_pkg::OP_CLOSE:
                begin
                    led_mode[idx] = 3'h0;
                    led_on[idx] = 1'b0;
                end
                default:
                begin
                    if (c.on_percent != 7'd0 && c.blink_period != 16'd0)
                    begin
                        // restore state is kept when re-blinking an already blinking LED
                        if (led_mode[idx] < lbc_pkg::MODE_BLINK)
                            lit_after_blink[idx] = led_mode[idx][0];
                        led_mode[idx] = lbc_pkg::MODE_BLINK |
                            ((c.blink_count == 8'd0) ? lbc_pkg::MODE_FLASH : 3'h0);
                        period_ms[idx] = c.blink_period;
                        duty_pct[idx] = (c.on_percent > lbc_pkg::FULL_PCT) ?
                                        lbc_pkg::FULL_PCT : c.on_percent;
                        blinks_to_go[idx] = c.blink_count;
                        due_ms[idx] = clock_ms;
                        blinks_started++;
                    end
                end
            endcase
        end
        if (c.op == lbc_pkg::OP_TICK)
        begin
            clock_ms = clock_ms + 32'd1;
            ticks_seen++;
        end
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            if ((led_mode[i] & lbc_pkg::MODE_BLINK) != 3'h0)
            begin
                if (c.op == lbc_pkg::OP_TICK)
                    best = min_wait(best, advance_led(i));
                else if (clock_ms < due_ms[i])
                    best = min_wait(best, 16'(due_ms[i] - clock_ms));
                else
                    best = min_wait(best, 16'd0);
            end
        end
        for (int i = 0; i < NUM_LEDS; i++)
            s.pins[i] = led_on[i] ? level_mask[i] : ~level_mask[i];
        s.wait_ms = best;
        return s;
    endfunction

    function automatic void add_cmd(logic [2:0] op_code, logic [1:0] idx, logic [7:0] count,
                                    logic [6:0] pct, logic [15:0] period);
        job_t j;
        j.kind = JOB_CMD;
        j.op = op_code;
        j.led_index = idx;
        j.blink_count = count;
        j.on_percent = pct;
        j.blink_period = period;
        j.mask_value = '0;
        j.gap_pct = sender_gap_pct;
        command_q.push_back(j);
    endfunction

    function automatic void add_mask_write(logic [2:0] value);
        job_t j;
        j.kind = JOB_MASK;
        j.op = '0;
        j.led_index = '0;
        j.blink_count = '0;
        j.on_percent = '0;
        j.blink_period = '0;
        j.mask_value = value;
        j.gap_pct = 0;
        command_q.push_back(j);
    endfunction

    // mostly ticks with short blinks so that runs complete; the rest is wide-range noise
    function automatic void add_random_cmd();
        int          r;
        logic [2:0]  op_code;
        logic [1:0]  idx;
        logic [7:0]  count;
        logic [6:0]  pct;
        logic [15:0] period;
        r = $urandom_range(99);
        if (r < 58)
            op_code = lbc_pkg::OP_TICK;
        else if (r < 72)
            op_code = lbc_pkg::OP_BLINK;
        else if (r < 80)
            op_code = lbc_pkg::OP_OPEN;
        else if (r < 87)
            op_code = lbc_pkg::OP_CLOSE;
        else if (r < 96)
            op_code = lbc_pkg::OP_TOGGLE;
        else
            op_code = 3'($urandom_range(7, 5));
        if ($urandom_range(11) == 0)
            idx = 2'd3;
        else
            idx = 2'($urandom_range(NUM_LEDS - 1));
        if ($urandom_range(7) == 0)
            count = 8'($urandom);
        else
            count = 8'($urandom_range(4));
        r = $urandom_range(19);
        if (r == 0)
            pct = 7'd0;
        else if (r < 4)
            pct = 7'($urandom);
        else
            pct = 7'($urandom_range(100, 1));
        r = $urandom_range(24);
        if (r == 0)
            period = 16'd0;
        else if (r < 3)
            period = 16'($urandom);
        else
            period = 16'($urandom_range(40, 1));
        add_cmd(op_code, idx, count, pct, period);
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : drive_beats
        job_t head;
        logic launch;
        logic start_n;
        logic quiet;
        if (rst_n)
        begin
            launch = 1'b0;
            case (drv_state)
                DRV_CMD:
                begin
                    if (!busy)
                    begin
                        head = command_q.pop_front();
                        expected_status_q.push_back(predict_status(head));
                        cmds_accepted++;
                        drv_state = DRV_IDLE;
                        launch = 1'b1;
                    end
                end
                DRV_SETUP:
                begin
                    penable <= 1'b1;
                    drv_state = DRV_ACCESS;
                end
                DRV_ACCESS:
                begin
                    if (pready)
                    begin
                        level_mask = command_q[0].mask_value;
                        masks_written++;
                        // straight into a read-back setup phase
                        pwrite <= 1'b0;
                        penable <= 1'b0;
                        drv_state = DRV_RSETUP;
                    end
                end
                DRV_RSETUP:
                begin
                    penable <= 1'b1;
                    drv_state = DRV_RACCESS;
                end
                DRV_RACCESS:
                begin
                    if (pready)
                    begin
                        if (prdata[2:0] !== level_mask)
                            report_mismatch($sformatf("on_level_mask read %b, wrote %b",
                                                      prdata[2:0], level_mask));
                        psel <= 1'b0;
                        penable <= 1'b0;
                        command_q.delete(0);
                        drv_state = DRV_IDLE;
                    end
                end
                default: launch = 1'b1;
            endcase
            if (launch)
            begin
                // done still high means the last result is being taken this edge
                quiet = (expected_status_q.size() == 0) && !done;
                start_n = 1'b0;
                if (command_q.size() != 0)
                begin
                    head = command_q[0];
                    case (head.kind)
                        JOB_CMD:
                        begin
                            if ($urandom_range(99) >= head.gap_pct)
                            begin
                                start_n = 1'b1;
                                op <= head.op;
                                led_index <= head.led_index;
                                blink_count <= head.blink_count;
                                on_percent <= head.on_percent;
                                blink_period <= head.blink_period;
                                drv_state = DRV_CMD;
                            end
                        end
                        JOB_MASK:
                        begin
                            if (quiet)
                            begin
                                psel <= 1'b1;
                                pwrite <= 1'b1;
                                penable <= 1'b0;
                                paddr <= lbc_pkg::ADDR_ON_LEVEL_MASK;
                                pwdata <= 32'(head.mask_value);
                                drv_state = DRV_SETUP;
                            end
                        end
                        default:
                        begin
                            if (quiet)
                                command_q.delete(0);
                        end
                    endcase
                end
                start <= start_n;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        status_t want;
        if (rst_n && done)
        begin
            if (expected_status_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result beat: pins %b wait %0d",
                                          pin_levels, next_wait));
            end
            else
            begin
                want = expected_status_q.pop_front();
                results_seen++;
                if (pin_levels !== want.pins)
                    report_mismatch($sformatf("beat %0d pin_levels %b, want %b",
                                              results_seen, pin_levels, want.pins));
                if (next_wait !== want.wait_ms)
                    report_mismatch($sformatf("beat %0d next_wait %0d, want %0d",
                                              results_seen, next_wait, want.wait_ms));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        level_mask = 3'd6;
        clock_ms = '0;
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            led_mode[i] = '0;
            blinks_to_go[i] = '0;
            duty_pct[i] = '0;
            period_ms[i] = '0;
            due_ms[i] = '0;
            lit_after_blink[i] = 1'b0;
            led_on[i] = 1'b0;
        end

        sender_gap_pct = 8;
        // directed: steady modes, a one-blink run that restores, forever flash with a
        // saturated duty, ignored blinks, re-blink while blinking, bad index, spare ops
        add_cmd(lbc_pkg::OP_TICK, 2'd0, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_OPEN, 2'd0, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_OPEN, 2'd1, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_OPEN, 2'd2, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_CLOSE, 2'd1, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_TOGGLE, 2'd1, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_TOGGLE, 2'd2, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_BLINK, 2'd0, 8'd1, 7'd50, 16'd2);
        add_cmd(lbc_pkg::OP_TICK, 2'd0, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_TICK, 2'd0, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_TICK, 2'd0, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_BLINK, 2'd1, 8'd0, 7'd127, 16'hFFFF);
        add_cmd(lbc_pkg::OP_BLINK, 2'd2, 8'd3, 7'd0, 16'd10);
        add_cmd(lbc_pkg::OP_BLINK, 2'd2, 8'd3, 7'd40, 16'd0);
        add_cmd(lbc_pkg::OP_BLINK, 2'd0, 8'd255, 7'd1, 16'd3);
        add_cmd(lbc_pkg::OP_TICK, 2'd0, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_BLINK, 2'd0, 8'd2, 7'd100, 16'd1);
        add_cmd(lbc_pkg::OP_OPEN, 2'd3, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_BLINK, 2'd3, 8'd1, 7'd50, 16'd4);
        add_cmd(3'd5, 2'd0, 8'hFF, 7'h7F, 16'hFFFF);
        add_cmd(3'd6, 2'd1, 8'd0, 7'd0, 16'd0);
        add_cmd(3'd7, 2'd2, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_TICK, 2'd0, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_TOGGLE, 2'd1, 8'd0, 7'd0, 16'd0);
        add_cmd(lbc_pkg::OP_TICK, 2'd0, 8'd0, 7'd0, 16'd0);

        add_mask_write(3'd7);
        repeat (215) add_random_cmd();
        // hold off until every result is back
        command_q.push_back('{JOB_DRAIN, 3'd0, 2'd0, 8'd0, 7'd0, 16'd0, 3'd0, 0});
        repeat (215) add_random_cmd();
        add_mask_write(3'd0);
        sender_gap_pct = 63;
        repeat (430) add_random_cmd();
        add_mask_write(3'($urandom_range(7)));
        sender_gap_pct = 0;
        repeat (220) add_random_cmd();
        add_mask_write(3'd5);
        repeat (220) add_random_cmd();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (command_q.size() != 0)
            @(posedge clk);
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_status_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_status_q.size()));

        $display("ran %0d commands (%0d ms ticks), %0d blinks started, %0d blink runs ended",
                 cmds_accepted, ticks_seen, blinks_started, runs_finished);
        $display("%0d result beats checked over %0d polarity settings, %0d mismatches",
                 results_seen, masks_written + 1, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: led_blink_controller.f
hdl/lbc_pkg.sv
hdl/lbc_mul.sv
hdl/lbc_apb_regs.sv
hdl/led_blink_controller.sv
test/tb_led_blink_controller.sv
